### rtl/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants for the dot-star pattern matcher: request kinds,
// sequencer states and the control structs passed between modules.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam logic [7:0] ANY_SYMBOL = 8'd46;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CLOSE = 1'b1
  } state_e;

  // sequencer strobes towards the datapath
  typedef struct packed {
    logic take;
    logic load;
    logic close;
    logic step;
    logic publish;
  } seq_t;

  // command broadcast along the cell row
  typedef struct packed {
    logic       rearm;
    logic       close;
    logic       step;
    logic [7:0] text;
  } cmd_t;

endpackage

### rtl/dsm_cell.sv
// ----------------------------------------------------------------------------
// dsm_cell
// One pattern position: holds its element and active bit, forwards the
// star skip and the symbol advance to the next position.
// ----------------------------------------------------------------------------
module dsm_cell #(
  parameter logic IsHead = 1'b0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dsm_pkg::cmd_t cmd_i,
  input  logic          wr_i,
  input  logic [7:0]    wr_symbol_i,
  input  logic          wr_star_i,
  input  logic          in_pat_i,
  input  logic          carry_i,
  input  logic          pass_i,
  output logic          act_o,
  output logic          carry_o,
  output logic          pass_o,
  output logic          chg_o
);

  logic [7:0] sym_q;
  logic       star_q;
  logic       act_q, act_d;
  logic       hit;
  logic       stay;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      sym_q  <= wr_symbol_i;
      star_q <= wr_star_i;
    end
  end

  assign hit     = (sym_q == dsm_pkg::ANY_SYMBOL) || (sym_q == cmd_i.text);
  assign carry_o = act_q & star_q & in_pat_i;
  assign pass_o  = act_q & hit & ~star_q & in_pat_i;
  assign stay    = act_q & hit & star_q & in_pat_i;
  assign chg_o   = carry_i & ~act_q;
  assign act_o   = act_q;

  always_comb begin
    priority if (cmd_i.rearm) begin
      act_d = IsHead;
    end else if (cmd_i.close) begin
      act_d = act_q | carry_i;
    end else if (cmd_i.step) begin
      act_d = stay | pass_i;
    end else begin
      act_d = act_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= IsHead;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

### rtl/dsm_ctrl.sv
// ----------------------------------------------------------------------------
// dsm_ctrl
// Request sequencer: takes requests, runs the closure until it settles, then
// applies the symbol step or hands the result to the output register.
// ----------------------------------------------------------------------------
module dsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    kind_i,
  input  logic          chg_i,
  input  logic          out_free_i,
  output logic          in_ready_o,
  output dsm_pkg::seq_t seq_o
);

  dsm_pkg::state_e state_q, state_d;
  logic            is_end_q, is_end_d;
  logic            is_scan;
  logic            is_load;

  always_comb begin
    is_scan = 1'b0;
    is_load = 1'b0;
    unique case (kind_i)
      dsm_pkg::KIND_LOAD: is_load = 1'b1;
      dsm_pkg::KIND_TEXT: is_scan = 1'b1;
      dsm_pkg::KIND_END:  is_scan = 1'b1;
      default: begin
        is_scan = 1'b0;
        is_load = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d  = state_q;
    is_end_d = is_end_q;
    unique case (state_q)
      dsm_pkg::ST_IDLE: begin
        if (in_valid_i && is_scan) begin
          state_d  = dsm_pkg::ST_CLOSE;
          is_end_d = (kind_i == dsm_pkg::KIND_END);
        end
      end
      dsm_pkg::ST_CLOSE: begin
        if (!chg_i && (!is_end_q || out_free_i)) begin
          state_d = dsm_pkg::ST_IDLE;
        end
      end
      default: state_d = dsm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    seq_o         = '0;
    unique case (state_q)
      dsm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        seq_o.take = in_valid_i;
        seq_o.load = in_valid_i && is_load;
      end
      dsm_pkg::ST_CLOSE: begin
        seq_o.close   = chg_i;
        seq_o.step    = !chg_i && !is_end_q;
        seq_o.publish = !chg_i && is_end_q && out_free_i;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dsm_pkg::ST_IDLE;
      is_end_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_end_q <= is_end_d;
    end
  end

endmodule

### rtl/dot_star_pattern_matcher.sv
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher
// Whole-string match of streamed text against a stored pattern of symbols
// with any-symbol and star elements, tracked as a row of position cells.
//
//   channel  signals                                    direction
//   in       in_valid_i/in_ready_o, kind_i, symbol_i,   request in
//            is_star_i, first_element_i
//   out      out_valid_o/out_ready_i, matched_o,        result out
//            pattern_overflow_o
//
// A pattern element load is handled in the idle state and does not leave it.
// A text symbol or end of text is taken in the idle state; the star closure then
// runs until no position changes, and then the symbol step or the result publish
// is applied. The closure moves one position per cycle along the cell row.
// End of text holds in the closure state while the previous result is untaken.
// After reset the pattern is empty and only position zero is active.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] symbol_i,
  input  logic       is_star_i,
  input  logic       first_element_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ELEMENTS);

  dsm_pkg::seq_t seq;
  dsm_pkg::cmd_t cmd;

  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         wr_idx;
  logic                  wr_en;
  logic                  ovf_q, ovf_d;
  logic [7:0]            text_q;
  logic                  act_last_q, act_last_d;
  logic [MAX_ELEMENTS:0] carry_w;
  logic [MAX_ELEMENTS:0] pass_w;
  logic [MAX_ELEMENTS-1:0] act_w;
  logic [MAX_ELEMENTS-1:0] chg_w;
  logic [MAX_ELEMENTS:0] act_all;
  logic                  chg_any;
  logic                  out_free;
  logic                  out_valid_q;
  logic                  matched_q;
  logic                  povf_q;

  assign out_free = !out_valid_q || out_ready_i;

  dsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .chg_i      (chg_any),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .seq_o      (seq)
  );

  always_ff @(posedge clk_i) begin
    if (seq.take) begin
      text_q <= symbol_i;
    end
  end

  assign cmd.rearm = seq.load || seq.publish;
  assign cmd.close = seq.close;
  assign cmd.step  = seq.step;
  assign cmd.text  = text_q;

  // pattern store write and fill count
  assign wr_idx = first_element_i ? '0 : count_q;
  assign wr_en  = seq.load && (first_element_i || (count_q < MaxCount));

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (seq.load) begin
      if (first_element_i) begin
        count_d = CW'(1);
        ovf_d   = 1'b0;
      end else if (count_q < MaxCount) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign carry_w[0] = 1'b0;
  assign pass_w[0]  = 1'b0;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    dsm_cell #(
      .IsHead (i == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .wr_i        (wr_en && (wr_idx == CW'(i))),
      .wr_symbol_i (symbol_i),
      .wr_star_i   (is_star_i),
      .in_pat_i    (CW'(i) < count_q),
      .carry_i     (carry_w[i]),
      .pass_i      (pass_w[i]),
      .act_o       (act_w[i]),
      .carry_o     (carry_w[i+1]),
      .pass_o      (pass_w[i+1]),
      .chg_o       (chg_w[i])
    );
  end

  // position past the last element
  always_comb begin
    priority if (cmd.rearm) begin
      act_last_d = 1'b0;
    end else if (cmd.close) begin
      act_last_d = act_last_q | carry_w[MAX_ELEMENTS];
    end else if (cmd.step) begin
      act_last_d = pass_w[MAX_ELEMENTS];
    end else begin
      act_last_d = act_last_q;
    end
  end

  assign chg_any = (|chg_w) || (carry_w[MAX_ELEMENTS] && !act_last_q);
  assign act_all = {act_last_q, act_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      act_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      act_last_q <= act_last_d;
      if (seq.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.publish) begin
      matched_q <= !ovf_q && act_all[count_q];
      povf_q    <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = povf_q;

  a_rearm_head_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rearm |=> act_all == (MAX_ELEMENTS + 1)'(1))
    else $error("rearm left positions other than the head active");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("pattern count above store size");

  a_no_match_on_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq.publish && ovf_q |=> out_valid_o && !matched_o && pattern_overflow_o)
    else $error("overflowed pattern reported a match");

  a_idle_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !seq.close && !seq.step && !seq.publish)
    else $error("active set updated while taking requests");

endmodule

### tb/dsm_match_checker.sv
// ----------------------------------------------------------------------------
// dsm_match_checker
// Watches both channels of the pattern matcher. Each accepted load, text or
// end request updates a private copy of the element store or of the active
// position set; every end of text queues its expected verdict. Each accepted
// result is checked against the oldest queued verdict; mismatches are counted.
// ----------------------------------------------------------------------------
module dsm_match_checker #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] symbol_i,
  input  logic       is_star_i,
  input  logic       first_element_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       matched_i,
  input  logic       pattern_overflow_i,
  output int         mismatch_count_o,
  output int         open_results_o
);

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic [7:0]            elem_sym [MAX_ELEMENTS];
  logic                  elem_star[MAX_ELEMENTS];
  int                    elem_count;
  logic [MAX_ELEMENTS:0] live_pos;
  logic                  overflowed;
  verdict_t              verdict_q[$];

  // starred elements may be skipped
  function automatic logic [MAX_ELEMENTS:0] skip_stars(logic [MAX_ELEMENTS:0] pos);
    for (int i = 0; i < elem_count; i++) begin
      if (pos[i] && elem_star[i]) pos[i+1] = 1'b1;
    end
    return pos;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [MAX_ELEMENTS:0] reach;
    logic [MAX_ELEMENTS:0] nxt;
    verdict_t              want;
    if (!rst_ni) begin
      elem_count       = 0;
      live_pos         = (MAX_ELEMENTS + 1)'(1);
      overflowed       = 1'b0;
      verdict_q.delete();
      mismatch_count_o = 0;
      open_results_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          dsm_pkg::KIND_LOAD: begin
            if (first_element_i) begin
              elem_count = 0;
              overflowed = 1'b0;
            end
            if (elem_count < MAX_ELEMENTS) begin
              elem_sym[elem_count]  = symbol_i;
              elem_star[elem_count] = is_star_i;
              elem_count++;
            end else begin
              overflowed = 1'b1;
            end
            live_pos = (MAX_ELEMENTS + 1)'(1);
          end
          dsm_pkg::KIND_TEXT: begin
            reach = skip_stars(live_pos);
            nxt   = '0;
            for (int i = 0; i < elem_count; i++) begin
              if (reach[i] && (elem_sym[i] == dsm_pkg::ANY_SYMBOL ||
                               elem_sym[i] == symbol_i)) begin
                if (elem_star[i]) nxt[i] = 1'b1;
                else nxt[i+1] = 1'b1;
              end
            end
            live_pos = nxt;
          end
          dsm_pkg::KIND_END: begin
            reach         = skip_stars(live_pos);
            want.matched  = !overflowed && reach[elem_count];
            want.overflow = overflowed;
            verdict_q.insert(verdict_q.size(), want);
            live_pos = (MAX_ELEMENTS + 1)'(1);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual matched=%0b overflow=%0b",
                   $time, matched_i, pattern_overflow_i);
          mismatch_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (matched_i !== want.matched) begin
            $display("%0t: matched expected %0b actual %0b", $time, want.matched, matched_i);
            mismatch_count_o++;
          end
          if (pattern_overflow_i !== want.overflow) begin
            $display("%0t: pattern_overflow expected %0b actual %0b",
                     $time, want.overflow, pattern_overflow_i);
            mismatch_count_o++;
          end
        end
      end
      open_results_o = verdict_q.size();
    end
  end

endmodule

### tb/tb_dot_star_pattern_matcher.sv
// ----------------------------------------------------------------------------
// tb_dot_star_pattern_matcher
// Drives the pattern matcher with a directed set of patterns and texts, then
// with random patterns (short ones mostly, a few past the store's capacity)
// and texts built to follow them, mixed with broken texts and ignored
// requests. Both sides idle at random; once the receiver holds off long enough
// to back the block up. The checker beside the block gives the verdict count.
// ----------------------------------------------------------------------------
module tb_dot_star_pattern_matcher;

  localparam int         MAX_ELEMENTS = 32;
  localparam logic [1:0] KIND_NONE    = 2'd3;
  localparam logic [7:0] SYM_A        = 8'd97;
  localparam logic [7:0] SYM_B        = 8'd98;
  localparam logic [7:0] SYM_STAR     = 8'd42;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] kind;
  logic [7:0] symbol;
  logic       is_star;
  logic       first_element;
  logic       out_valid;
  logic       out_ready;
  logic       matched;
  logic       pattern_overflow;
  int         mismatches;
  int         open_results;

  logic [7:0] stored_sym [MAX_ELEMENTS];
  logic       stored_star[MAX_ELEMENTS];
  int         stored_len   = 0;
  int         sent_items   = 0;
  bit         sender_gaps  = 1'b1;
  bit         hold_off_req = 1'b0;

  always #5 clk = ~clk;

  dot_star_pattern_matcher #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .kind_i            (kind),
    .symbol_i          (symbol),
    .is_star_i         (is_star),
    .first_element_i   (first_element),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .matched_o         (matched),
    .pattern_overflow_o(pattern_overflow)
  );

  dsm_match_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) match_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .kind_i            (kind),
    .symbol_i          (symbol),
    .is_star_i         (is_star),
    .first_element_i   (first_element),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .matched_i         (matched),
    .pattern_overflow_i(pattern_overflow),
    .mismatch_count_o  (mismatches),
    .open_results_o    (open_results)
  );

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 9);
    return (r < 5) ? SYM_A : (r < 8) ? SYM_B : (r < 9) ? SYM_STAR : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pattern_byte();
    int r;
    r = $urandom_range(0, 9);
    return (r < 4) ? SYM_A : (r < 7) ? SYM_B : (r < 9) ? dsm_pkg::ANY_SYMBOL : text_byte();
  endfunction

  task automatic send_request(input logic [1:0] k, input logic [7:0] s, input logic st,
                              input logic f);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    symbol        <= s;
    is_star       <= st;
    first_element <= f;
    do @(posedge clk); while (!in_ready);
    if (k != KIND_NONE) sent_items++;
    if (k == dsm_pkg::KIND_LOAD) begin
      if (f) stored_len = 0;
      if (stored_len < MAX_ELEMENTS) begin
        stored_sym[stored_len]  = s;
        stored_star[stored_len] = st;
        stored_len++;
      end
    end
  endtask

  // receiver
  initial begin
    int stall;
    bit recv_gaps;
    recv_gaps = 1'b1;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = recv_gaps ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 31) == 0) recv_gaps = !recv_gaps;
    end
  end

  // stimulus
  initial begin
    int         pick;
    int         len;
    int         reps;
    int         burst_left;
    bit         long_pat;
    bit         pressure_done;
    logic [7:0] c;
    burst_left    = 0;
    pressure_done = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    kind          <= dsm_pkg::KIND_LOAD;
    symbol        <= 8'd0;
    is_star       <= 1'b0;
    first_element <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern against empty and non-empty text
    send_request(dsm_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, SYM_A, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_END, 8'd255, 1'b1, 1'b1);
    // starred element against empty text
    send_request(dsm_pkg::KIND_LOAD, SYM_A, 1'b1, 1'b1);
    send_request(dsm_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
    // extreme bytes, any-symbol repeat, literal star symbol
    send_request(dsm_pkg::KIND_LOAD, 8'd0, 1'b0, 1'b1);
    send_request(dsm_pkg::KIND_LOAD, 8'd255, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_LOAD, dsm_pkg::ANY_SYMBOL, 1'b1, 1'b0);
    send_request(dsm_pkg::KIND_LOAD, SYM_STAR, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, 8'd0, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, 8'd255, 1'b1, 1'b1);
    send_request(dsm_pkg::KIND_TEXT, SYM_STAR, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
    send_request(KIND_NONE, 8'd255, 1'b1, 1'b1);
    send_request(dsm_pkg::KIND_TEXT, 8'd0, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, 8'd255, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, 8'd7, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, SYM_STAR, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, 8'd0, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, 8'd255, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_TEXT, 8'd43, 1'b0, 1'b0);
    send_request(dsm_pkg::KIND_END, 8'd0, 1'b0, 1'b0);

    while (sent_items < 1950) begin
      pick = $urandom_range(0, 99);
      if (!pressure_done && sent_items >= 900) begin
        pressure_done = 1'b1;
        hold_off_req  = 1'b1;
        burst_left    = 12;
      end
      if (burst_left > 0) begin
        burst_left--;
        sender_gaps = 1'b0;
        pick        = $urandom_range(18, 99);
      end else if ($urandom_range(0, 15) == 0) begin
        sender_gaps = !sender_gaps;
      end

      if (pick < 12) begin
        long_pat = ($urandom_range(0, 19) == 0);
        len      = long_pat ? $urandom_range(28, 36) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          send_request(dsm_pkg::KIND_LOAD, pattern_byte(),
                       long_pat ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 2) == 0),
                       j == 0);
        end
      end else if (pick < 15) begin
        send_request(dsm_pkg::KIND_LOAD, pattern_byte(), 1'($urandom), 1'b0);
      end else if (pick < 18) begin
        send_request(KIND_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        if (pick >= 30) begin
          // text that follows the stored pattern, lightly corrupted now and then
          for (int e = 0; e < stored_len; e++) begin
            reps = stored_star[e] ? $urandom_range(0, (stored_len > 8) ? 1 : 3) : 1;
            repeat (reps) begin
              c = (stored_sym[e] == dsm_pkg::ANY_SYMBOL) ? text_byte() : stored_sym[e];
              if ($urandom_range(0, 39) == 0) c = text_byte();
              send_request(dsm_pkg::KIND_TEXT, c, 1'($urandom), 1'($urandom));
            end
          end
          if ($urandom_range(0, 9) == 0) begin
            send_request(dsm_pkg::KIND_TEXT, text_byte(), 1'b0, 1'b0);
          end
        end else begin
          repeat ($urandom_range(0, 10)) begin
            send_request(dsm_pkg::KIND_TEXT, text_byte(), 1'($urandom), 1'($urandom));
          end
        end
        send_request(dsm_pkg::KIND_END, 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (open_results != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && open_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
